// File: rtl/pdsr_pkg.sv
// shared types, codes and constants of the path dot segment remover
package pdsr_pkg;

   localparam int BUF_LEN_DEFAULT     = 4096;
   localparam int STACK_DEPTH_DEFAULT = 2048;

   localparam int MID_DEPTH = 2;
   localparam int MID_PW    = $clog2(MID_DEPTH);
   localparam int MID_CW    = $clog2(MID_DEPTH + 1);

   localparam int OUT_DEPTH = 4;
   localparam int OUT_PW    = $clog2(OUT_DEPTH);
   localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

   localparam logic [7:0] SEP_CHAR = 8'h2F;
   localparam logic [7:0] DOT_CHAR = 8'h2E;

   localparam logic ACT_FEED = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef enum logic [1:0] {
      PAT_EMPTY = 2'd0,
      PAT_ONE   = 2'd1,
      PAT_TWO   = 2'd2,
      PAT_OTHER = 2'd3
   } pdsr_pat_type;

   typedef enum logic [1:0] {
      SRC_ZERO  = 2'd0,
      SRC_SLASH = 2'd1,
      SRC_RAM   = 2'd2
   } pdsr_src_type;

   typedef struct packed {
      logic        action;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [11:0] read_index;
   } pdsr_req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [12:0] out_length;
      logic        path_complete;
      logic        overflow;
   } pdsr_rsp_type;

   typedef struct packed {
      logic        action;
      logic        last;
      logic        is_sep;
      logic        is_dot;
      logic [7:0]  data;
      logic [11:0] read_index;
   } pdsr_cmd_type;

   function automatic pdsr_pat_type pdsr_next_pat(input pdsr_pat_type pat, input logic is_dot);
      pdsr_pat_type result;
      if (!is_dot) begin
         result = PAT_OTHER;
      end else begin
         case (pat)
            PAT_EMPTY: result = PAT_ONE;
            PAT_ONE:   result = PAT_TWO;
            default:   result = PAT_OTHER;
         endcase
      end
      return result;
   endfunction

endpackage

// File: rtl/pdsr_ram.sv
// generic single write port ram with registered read
module pdsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/pdsr_front.sv
// input side: takes words, classifies the byte and queues commands for the back end
module pdsr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  pdsr_pkg::pdsr_req_type req_data,
   output logic                  cmd_valid,
   output pdsr_pkg::pdsr_cmd_type cmd_data,
   input  logic                  cmd_take
);
   import pdsr_pkg::*;

   pdsr_cmd_type      entry_ff [MID_DEPTH];
   pdsr_cmd_type      cmd_in;
   logic [MID_PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [MID_PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [MID_CW-1:0] count_ff, count_in;
   logic              push_ok;
   logic              take_ok;

   always_comb begin
      cmd_in.action     = req_data.action;
      cmd_in.last       = req_data.last_byte;
      cmd_in.is_sep     = req_data.data_byte == SEP_CHAR;
      cmd_in.is_dot     = req_data.data_byte == DOT_CHAR;
      cmd_in.data       = req_data.data_byte;
      cmd_in.read_index = req_data.read_index;
   end

   assign req_full  = count_ff == MID_CW'(MID_DEPTH);
   assign cmd_valid = count_ff != '0;
   assign cmd_data  = entry_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign take_ok   = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + MID_PW'(1) : wr_ptr_ff;
      rd_ptr_in = take_ok ? rd_ptr_ff + MID_PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !take_ok) begin
         count_in = count_ff + MID_CW'(1);
      end else if (take_ok && !push_ok) begin
         count_in = count_ff - MID_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// File: rtl/pdsr_rsp_queue.sv
// result side queue of finished words
module pdsr_rsp_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rsp_push,
   input  pdsr_pkg::pdsr_rsp_type        rsp_word,
   output logic [pdsr_pkg::OUT_CW-1:0]  rsp_count,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output pdsr_pkg::pdsr_rsp_type        rsp_data
);
   import pdsr_pkg::*;

   pdsr_rsp_type      entry_ff [OUT_DEPTH];
   logic [OUT_PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUT_PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUT_CW-1:0] count_ff, count_in;
   logic              pop_ok;

   assign rsp_empty = count_ff == '0;
   assign rsp_count = count_ff;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop_ok    = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = rsp_push ? wr_ptr_ff + OUT_PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + OUT_PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (rsp_push && !pop_ok) begin
         count_in = count_ff + OUT_CW'(1);
      end else if (pop_ok && !rsp_push) begin
         count_in = count_ff - OUT_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         entry_ff[wr_ptr_ff] <= rsp_word;
      end
   end

endmodule

// File: rtl/pdsr_back.sv
// back end: path state, segment stack, canonical buffer banks and result stage
module pdsr_back #(
   parameter int BUF_LEN     = pdsr_pkg::BUF_LEN_DEFAULT,
   parameter int STACK_DEPTH = pdsr_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   input  pdsr_pkg::pdsr_cmd_type       cmd_data,
   output logic                        cmd_take,
   input  logic [pdsr_pkg::OUT_CW-1:0] rsp_count,
   output logic                        rsp_push,
   output pdsr_pkg::pdsr_rsp_type       rsp_word
);
   import pdsr_pkg::*;

   localparam int LW  = $clog2(BUF_LEN + 1);
   localparam int AW  = $clog2(BUF_LEN);
   localparam int SW  = LW + 1;
   localparam int EW  = (LW > 13) ? LW : 13;
   localparam int BD  = (BUF_LEN + 1) / 2;
   localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
   localparam int CW  = $clog2(STACK_DEPTH + 1);
   localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // path state
   logic [LW-1:0]  cl_ff, cl_in;
   logic [CW-1:0]  sc_ff, sc_in;
   logic [LW-1:0]  sl_ff, sl_in;
   pdsr_pat_type   pat_ff, pat_in;
   logic           ovf_ff, ovf_in;
   logic           done_ff, done_in;
   logic [AW-1:0]  top_ff, top_in;
   logic           refill_ff, refill_in;

   // result stage
   logic           st_valid_ff, st_valid_in;
   pdsr_src_type   st_src_ff, st_src_in;
   logic           st_bank_ff, st_bank_in;
   logic [12:0]    st_len_ff, st_len_in;
   logic           st_done_ff, st_done_in;
   logic           st_ovf_ff, st_ovf_in;

   logic           exec_go;
   logic           feed;
   logic           fresh;
   logic [LW-1:0]  cl0;
   logic [CW-1:0]  sc0;
   logic [LW-1:0]  sl0;
   pdsr_pat_type   pat0;
   logic           ovf0;
   logic [SW-1:0]  slot;
   logic           fits;
   logic           data_ok;
   logic           slash_we;
   logic [LW-1:0]  sl1;
   pdsr_pat_type   pat1;
   logic           do_close;
   logic           do_pop;
   logic           do_push;
   logic [EW-1:0]  len_ext;
   logic [OUT_CW:0] credit;
   logic [AW-1:0]  top_now;

   logic           stk_we;
   logic [SAW-1:0] stk_wr_addr;
   logic           stk_re;
   logic [SAW-1:0] stk_rd_addr;
   logic [AW-1:0]  stk_rd_data;

   logic           bank0_we, bank1_we;
   logic [BAW-1:0] bank0_wr_addr, bank1_wr_addr;
   logic [7:0]     bank0_wr_data, bank1_wr_data;
   logic           bank_re;
   logic [BAW-1:0] bank_rd_addr;
   logic [7:0]     bank0_rd_data, bank1_rd_data;
   logic [BAW-1:0] cl_row;
   logic [BAW-1:0] slot_row;

   assign credit   = (OUT_CW + 1)'(rsp_count) + (OUT_CW + 1)'(st_valid_ff);
   assign exec_go  = cmd_valid && (credit < (OUT_CW + 1)'(OUT_DEPTH));
   assign cmd_take = exec_go;

   always_comb begin
      feed  = exec_go && (cmd_data.action == ACT_FEED);
      fresh = feed && done_ff;
      cl0   = fresh ? '0 : cl_ff;
      sc0   = fresh ? '0 : sc_ff;
      sl0   = fresh ? '0 : sl_ff;
      pat0  = fresh ? PAT_EMPTY : pat_ff;
      ovf0  = fresh ? 1'b0 : ovf_ff;

      // top of stack, with the entry read back after a pop
      top_now = refill_ff ? stk_rd_data : top_ff;

      slot     = SW'(cl0) + SW'(sl0) + SW'(1);
      fits     = slot < SW'(BUF_LEN);
      data_ok  = feed && !cmd_data.is_sep && fits;
      slash_we = data_ok && (sl0 == '0);
      sl1      = data_ok ? sl0 + LW'(1) : sl0;
      pat1     = data_ok ? pdsr_next_pat(pat0, cmd_data.is_dot) : pat0;

      do_close = feed && (cmd_data.is_sep || cmd_data.last);
      do_pop   = do_close && (pat1 == PAT_TWO) && (sc0 != '0);
      do_push  = do_close && (pat1 == PAT_OTHER) && (sc0 != CW'(STACK_DEPTH));

      ovf_in = ovf0
               || (feed && !cmd_data.is_sep && !fits)
               || (do_close && (pat1 == PAT_OTHER) && (sc0 == CW'(STACK_DEPTH)));

      if (do_pop) begin
         cl_in = LW'(top_now);
         sc_in = sc0 - CW'(1);
      end else if (do_push) begin
         cl_in = cl0 + sl1 + LW'(1);
         sc_in = sc0 + CW'(1);
      end else begin
         cl_in = cl0;
         sc_in = sc0;
      end

      sl_in   = do_close ? '0 : sl1;
      pat_in  = do_close ? PAT_EMPTY : pat1;
      done_in = feed ? cmd_data.last : done_ff;

      if (do_push) begin
         top_in = AW'(cl0);
      end else begin
         top_in = top_now;
      end
      refill_in = do_pop && (sc0 > CW'(1));

      stk_we      = do_push && (sc0 != '0);
      stk_wr_addr = SAW'(sc0 - CW'(1));
      stk_re      = refill_in;
      stk_rd_addr = SAW'(sc0 - CW'(2));
   end

   // '/' opening a segment and its first byte land in opposite banks
   always_comb begin
      cl_row        = BAW'(EW'(cl0) >> 1);
      slot_row      = BAW'(EW'(slot) >> 1);
      bank0_we      = (slash_we && !cl0[0]) || (data_ok && !slot[0]);
      bank1_we      = (slash_we && cl0[0]) || (data_ok && slot[0]);
      bank0_wr_addr = (data_ok && !slot[0]) ? slot_row : cl_row;
      bank1_wr_addr = (data_ok && slot[0]) ? slot_row : cl_row;
      bank0_wr_data = (data_ok && !slot[0]) ? cmd_data.data : SEP_CHAR;
      bank1_wr_data = (data_ok && slot[0]) ? cmd_data.data : SEP_CHAR;
      bank_re       = exec_go && (cmd_data.action == ACT_READ);
      bank_rd_addr  = BAW'(EW'(cmd_data.read_index) >> 1);
   end

   always_comb begin
      st_valid_in = exec_go;
      st_bank_in  = cmd_data.read_index[0];
      if (cmd_data.action == ACT_READ) begin
         if (cl_ff == '0) begin
            st_src_in = (cmd_data.read_index == '0) ? SRC_SLASH : SRC_ZERO;
         end else if (EW'(cmd_data.read_index) < EW'(cl_ff)) begin
            st_src_in = SRC_RAM;
         end else begin
            st_src_in = SRC_ZERO;
         end
      end else begin
         st_src_in = SRC_ZERO;
      end
      len_ext    = (cl_in == '0) ? EW'(1) : EW'(cl_in);
      st_len_in  = len_ext[12:0];
      st_done_in = done_in;
      st_ovf_in  = ovf_in;
   end

   always_comb begin
      rsp_push               = st_valid_ff;
      rsp_word.out_length    = st_len_ff;
      rsp_word.path_complete = st_done_ff;
      rsp_word.overflow      = st_ovf_ff;
      case (st_src_ff)
         SRC_RAM:   rsp_word.out_byte = st_bank_ff ? bank1_rd_data : bank0_rd_data;
         SRC_SLASH: rsp_word.out_byte = SEP_CHAR;
         default:   rsp_word.out_byte = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cl_ff       <= '0;
         sc_ff       <= '0;
         sl_ff       <= '0;
         pat_ff      <= PAT_EMPTY;
         ovf_ff      <= 1'b0;
         done_ff     <= 1'b0;
         refill_ff   <= 1'b0;
         st_valid_ff <= 1'b0;
      end else begin
         refill_ff   <= refill_in;
         st_valid_ff <= st_valid_in;
         if (exec_go) begin
            cl_ff   <= cl_in;
            sc_ff   <= sc_in;
            sl_ff   <= sl_in;
            pat_ff  <= pat_in;
            ovf_ff  <= ovf_in;
            done_ff <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (exec_go) begin
         st_src_ff  <= st_src_in;
         st_bank_ff <= st_bank_in;
         st_len_ff  <= st_len_in;
         st_done_ff <= st_done_in;
         st_ovf_ff  <= st_ovf_in;
      end
   end

   pdsr_ram #(
      .WIDTH (AW),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wr_addr),
      .wr_data (top_now),
      .rd_en   (stk_re),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   pdsr_ram #(
      .WIDTH (8),
      .DEPTH (BD)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (bank0_we),
      .wr_addr (bank0_wr_addr),
      .wr_data (bank0_wr_data),
      .rd_en   (bank_re),
      .rd_addr (bank_rd_addr),
      .rd_data (bank0_rd_data)
   );

   pdsr_ram #(
      .WIDTH (8),
      .DEPTH (BD)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (bank1_we),
      .wr_addr (bank1_wr_addr),
      .wr_data (bank1_wr_data),
      .rd_en   (bank_re),
      .rd_addr (bank_rd_addr),
      .rd_data (bank1_rd_data)
   );

`ifndef SYNTHESIS
   // a second pop needs two more bytes, so it never meets the refill cycle
   a_refill_no_pop: assert property (@(posedge clock) disable iff (reset)
      refill_ff |-> !do_pop)
      else $error("stack refill collides with pop");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sc_ff <= CW'(STACK_DEPTH))
      else $error("stack count past depth");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      cl_ff <= LW'(BUF_LEN))
      else $error("committed length past buffer");

   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (rsp_count < OUT_CW'(OUT_DEPTH)))
      else $error("result queue overrun");
`endif

endmodule

// File: rtl/path_dot_segment_remover_core.sv
// top level of the streaming unix path canonicalizer
// Takes one word per clock while the queues have room: a path byte to feed or an
// index to read back, and returns one result word per input word, in order. A
// word passes from the command queue through the result stage register into the
// result queue, and the block sustains one word per cycle unless the result
// queue backs up: every byte does one buffer write, or one segment stack push
// or pop, and the stack keeps its top entry in a register so that a pop needs no
// ram read in its own cycle. The canonical buffer is two
// byte-wide rams of half the buffer length each, so a segment's leading slash
// and its first byte are written in the same cycle; the segment stack is one
// ram of STACK_DEPTH entries. Neither ram is cleared after reset, and words are
// accepted from the first cycle. Overflow of either buffer or stack sets the
// overflow bit and drops the excess; feeding after the last byte of a path
// starts a new one.
module path_dot_segment_remover_core #(
   parameter int BUF_LEN     = pdsr_pkg::BUF_LEN_DEFAULT,
   parameter int STACK_DEPTH = pdsr_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  pdsr_pkg::pdsr_req_type req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output pdsr_pkg::pdsr_rsp_type rsp_data
);
   import pdsr_pkg::*;

   logic              cmd_valid;
   pdsr_cmd_type      cmd_data;
   logic              cmd_take;
   logic [OUT_CW-1:0] rsp_count;
   logic              rsp_push;
   pdsr_rsp_type      rsp_word;

   pdsr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take)
   );

   pdsr_back #(
      .BUF_LEN     (BUF_LEN),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_word  (rsp_word)
   );

   pdsr_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .rsp_push  (rsp_push),
      .rsp_word  (rsp_word),
      .rsp_count (rsp_count),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
